// ----- rtl/core/mrec_pkg.sv -----
// Package for the minimum-rank eviction cache: payload structs and shared types.
// No dependencies; used by every module under rtl/core.
`default_nettype none
package mrec_pkg;
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] fill_value;
    logic signed [31:0] fill_rank;
  } in_word_t;

  typedef struct packed {
    logic hit;
    logic [31:0] entry_value;
    logic signed [31:0] entry_rank;
    logic evicted;
    logic [7:0] occupancy;
  } out_word_t;
endpackage
`default_nettype wire

// ----- rtl/core/mrec_front.sv -----
// Front end: accepts request words into a two-entry queue for the back end.
// Depends on mrec_pkg.
`default_nettype none
module mrec_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mrec_pkg::in_word_t in_word,
  output logic                   q_valid,
  input  wire logic              q_pop,
  output mrec_pkg::in_word_t     q_word
);
  import mrec_pkg::*;

  in_word_t  slot_r [2];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;
  logic      push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_word   = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= in_word;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop && q_valid) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop && q_valid};
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/mrec_back.sv -----
// Back end: scans the slot memories for a key match and the minimum rank; on a
// miss it evicts when full and appends. Depends on mrec_pkg.
`default_nettype none
module mrec_back #(
  parameter int ENTRIES   = 128,
  parameter int KEY_BITS  = 32,
  parameter int DATA_BITS = 32,
  parameter int RANK_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [7:0]         cfg_wdata,
  input  wire logic               q_valid,
  output logic                    q_pop,
  input  wire mrec_pkg::in_word_t q_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mrec_pkg::out_word_t     out_word
);
  import mrec_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_RDLAST, S_MOVE, S_APPEND, S_RESP
  } state_t;

  logic [KEY_BITS-1:0]  mem_key [ENTRIES];
  logic [DATA_BITS-1:0] mem_val [ENTRIES];
  logic [RANK_BITS-1:0] mem_rank [ENTRIES];

  state_t state_r;
  logic [CW-1:0] count_r, cap_r, idx_r;
  logic [CW-1:0] cap_nxt;
  logic [KEY_BITS-1:0]  key_r, rd_key_r;
  logic [DATA_BITS-1:0] val_r, rd_val_r;
  logic [RANK_BITS-1:0] rank_r, rd_rank_r, min_rank_r;
  logic [IW-1:0] rd_idx_r, victim_r, min_idx_r;
  logic rd_vld_r, found_r, have_min_r, ev_r;
  logic [IW-1:0] rd_addr;
  logic rd_en;
  logic we;
  logic [IW-1:0] wa;
  logic [KEY_BITS-1:0]  wk;
  logic [DATA_BITS-1:0] wv;
  logic [RANK_BITS-1:0] wr;

  // Rank order: flip the sign bit so an unsigned compare orders signed ranks.
  function automatic logic rank_lt(input logic [RANK_BITS-1:0] a,
                                   input logic [RANK_BITS-1:0] b);
    logic [RANK_BITS-1:0] sb;
    sb = {1'b1, {(RANK_BITS-1){1'b0}}};
    return (a ^ sb) < (b ^ sb);
  endfunction

  always_comb begin
    if (cfg_wdata == 8'd0) begin
      cap_nxt = CW'(1);
    end else if ({{CW{1'b0}}, cfg_wdata} > (CW+8)'(ENTRIES)) begin
      cap_nxt = CW'(ENTRIES);
    end else begin
      cap_nxt = CW'(cfg_wdata);
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_r[IW-1:0];
    we = 1'b0; wa = rd_idx_r; wk = key_r; wv = val_r; wr = rank_r;
    case (state_r)
      S_SCAN:   rd_en = (idx_r < count_r) && !found_r;
      S_DECIDE: begin
        rd_en = 1'b1;
        rd_addr = IW'(count_r - CW'(1));
      end
      S_MOVE: begin
        we = 1'b1; wa = victim_r; wk = rd_key_r; wv = rd_val_r; wr = rd_rank_r;
      end
      S_APPEND: begin
        we = (count_r < CW'(ENTRIES)); wa = count_r[IW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key_r  <= mem_key[rd_addr];
      rd_val_r  <= mem_val[rd_addr];
      rd_rank_r <= mem_rank[rd_addr];
      rd_idx_r  <= rd_addr;
    end
    if (we) begin
      mem_key[wa]  <= wk;
      mem_val[wa]  <= wv;
      mem_rank[wa] <= wr;
    end
  end

  assign q_pop = (state_r == S_IDLE) && q_valid && !cfg_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      cap_r     <= CW'(ENTRIES);
      out_valid <= 1'b0;
      rd_vld_r  <= 1'b0;
    end else begin
      rd_vld_r <= rd_en && (state_r == S_SCAN);
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (cfg_we) begin
            cap_r   <= cap_nxt;
            count_r <= '0;
          end else if (q_valid) begin
            key_r      <= KEY_BITS'(q_word.key);
            val_r      <= DATA_BITS'(q_word.fill_value);
            rank_r     <= RANK_BITS'(q_word.fill_rank);
            idx_r      <= '0;
            found_r    <= 1'b0;
            have_min_r <= 1'b0;
            ev_r       <= 1'b0;
            state_r    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Read data arrives in the cycle after its address; compare the registered word.
          if (rd_vld_r) begin
            if (rd_key_r == key_r && !found_r) begin
              found_r <= 1'b1;
            end
            if (!have_min_r || rank_lt(rd_rank_r, min_rank_r)) begin
              have_min_r <= 1'b1;
              min_rank_r <= rd_rank_r;
              min_idx_r  <= rd_idx_r;
            end
          end
          if (rd_en) begin
            idx_r <= idx_r + CW'(1);
          end else if (!rd_vld_r) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          victim_r <= min_idx_r;
          if (found_r) begin
            state_r <= S_RDLAST;
          end else if (count_r >= cap_r && count_r != '0) begin
            ev_r    <= 1'b1;
            state_r <= S_RDLAST;
          end else begin
            state_r <= S_APPEND;
          end
        end
        S_RDLAST: begin
          if (found_r) begin
            state_r <= S_RESP;
          end else begin
            state_r <= S_MOVE;
          end
        end
        S_MOVE: begin
          count_r <= count_r - CW'(1);
          state_r <= S_APPEND;
        end
        S_APPEND: begin
          if (count_r < CW'(ENTRIES)) begin
            count_r <= count_r + CW'(1);
          end
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Hit data is picked up by the read of the matching slot in the scan.
  logic [DATA_BITS-1:0] hit_val_r;
  logic [RANK_BITS-1:0] hit_rank_r;
  always_ff @(posedge clk) begin
    if (state_r == S_SCAN && rd_vld_r && rd_key_r == key_r && !found_r) begin
      hit_val_r  <= rd_val_r;
      hit_rank_r <= rd_rank_r;
    end
    if (state_r == S_RESP && (!out_valid || out_ready)) begin
      out_word.hit         <= found_r;
      out_word.entry_value <= found_r ? 32'(hit_val_r) : 32'(val_r);
      out_word.entry_rank  <= found_r ? 32'(signed'(hit_rank_r))
                                      : 32'(signed'(rank_r));
      out_word.evicted     <= ev_r;
      out_word.occupancy   <= 8'(count_r);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/min_rank_eviction_cache_top.sv -----
// Top level of the minimum-rank eviction cache.
// Channels: in_valid/in_ready carry a request word (key, fill value, fill rank);
// out_valid/out_ready carry the response word (hit, value, rank, evicted,
// occupancy). cfg_we with cfg_wdata writes the capacity and empties the cache;
// write it only while the block is idle.
// The back end works on one word at a time and takes the next word right after
// it raises out_valid. Its work on a word is a scan of the slot memory that reads
// one slot per cycle and stops at a key match; on a miss it then moves the last
// slot into the minimum-rank slot when the cache is full, and appends the word.
// A two-word queue in front accepts new words while the back end is busy.
// Reset clears occupancy and sets capacity to ENTRIES; slots need no clearing.
// When the receiver stalls, the response word holds and the back end waits before raising its next response.
// Depends on mrec_pkg, mrec_front and mrec_back.
`default_nettype none
module min_rank_eviction_cache_top #(
  parameter int ENTRIES   = 128,
  parameter int KEY_BITS  = 32,
  parameter int DATA_BITS = 32,
  parameter int RANK_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire mrec_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mrec_pkg::out_word_t      out_word,
  input  wire logic                cfg_we,
  input  wire logic [7:0]          cfg_wdata
);
  import mrec_pkg::*;

  logic     q_valid, q_pop;
  in_word_t q_word;

  mrec_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_word,
    .q_valid, .q_pop, .q_word
  );

  mrec_back #(
    .ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS),
    .DATA_BITS(DATA_BITS), .RANK_BITS(RANK_BITS)
  ) u_back (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .q_valid, .q_pop, .q_word,
    .out_valid, .out_ready, .out_word
  );

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("response word dropped while stalled");
  a_hit_no_ev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_word.hit && out_word.evicted))
    else $error("hit reported with eviction");
  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.hit |-> out_word.occupancy != 8'd0)
    else $error("fill left cache empty");
endmodule
`default_nettype wire
